@@ src/i2crm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants for the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned BIT_CNT_W = 4;

  localparam logic [ADDR_W-1:0]    DEV_ADDR_RST  = 8'hDE;
  localparam logic [COUNT_W-1:0]   MAX_BYTES     = 9'd256;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic               start_cmd;
    logic               operation;
    logic [ADDR_W-1:0]  reg_address;
    logic [COUNT_W-1:0] byte_count;
    logic [7:0]         write_data;
    logic               sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       byte_request;
    logic [7:0] read_data;
    logic       read_valid;
    logic       nack_seen;
    logic       busy_res;
    logic       done_res;
  } out_item_t;

  typedef enum logic [17:0] {
    PH_IDLE      = 18'h00001,
    PH_S_FALL    = 18'h00002,
    PH_S_LOW     = 18'h00004,
    PH_BIT_LOW   = 18'h00008,
    PH_BIT_HIGH  = 18'h00010,
    PH_ACK_LOW   = 18'h00020,
    PH_ACK_HIGH  = 18'h00040,
    PH_RX_LOW    = 18'h00080,
    PH_RX_HIGH   = 18'h00100,
    PH_MACK_LOW  = 18'h00200,
    PH_MACK_HIGH = 18'h00400,
    PH_RS_REL    = 18'h00800,
    PH_RS_HIGH   = 18'h01000,
    PH_RS_FALL   = 18'h02000,
    PH_RS_LOW    = 18'h04000,
    PH_P_LOW     = 18'h08000,
    PH_P_HIGH    = 18'h10000,
    PH_P_REL     = 18'h20000
  } phase_t;

  // which byte the shared bit sequencer is sending
  typedef enum logic [1:0] {
    STG_DEV   = 2'd0,
    STG_REG   = 2'd1,
    STG_WDATA = 2'd2,
    STG_RADR  = 2'd3
  } stage_t;

endpackage

@@ src/i2c_register_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master
// Open-drain I2C master for register writes and reads, one bus phase per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one bus phase tick from an external prescaler and
// yields exactly one result transaction carrying the SCL/SDA levels and flags
// for that tick. The phase state machine takes one transition per cycle, so a
// tick can be accepted every clock; the result appears in the next cycle from
// the output register. The input stalls only while that register holds a
// result the consumer has not taken. The device write address register may
// be written only while no transaction is on the bus.
module i2c_register_master
  import i2crm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

  logic [ADDR_W-1:0] dev_addr_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  out_item_t         res;
  logic              accept;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_wr_en) begin
      dev_addr_r <= cfg_wr_data;
    end
  end

  i2crm_fsm u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (accept),
    .tick     (in_data),
    .dev_addr (dev_addr_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

endmodule

@@ src/i2crm_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_fsm
// Bus phase state machine: one phase tick per advance, result is combinational.
// ----------------------------------------------------------------------------
module i2crm_fsm
  import i2crm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  in_item_t          tick,
  input  logic [ADDR_W-1:0] dev_addr,
  output out_item_t         res
);

  phase_t               phase_r, phase_nxt;
  stage_t               stage_r, stage_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [COUNT_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic                 read_mode_r, read_mode_nxt;
  logic [ADDR_W-1:0]    reg_addr_r, reg_addr_nxt;

  logic [BIT_CNT_W-1:0] bit_cnt_inc;
  logic [COUNT_W-1:0]   bytes_dec;
  logic [COUNT_W-1:0]   count_sat;
  logic [7:0]           shift_ld;
  logic [7:0]           rx_shift;

  assign bit_cnt_inc = bit_cnt_r + 4'd1;
  assign bytes_dec   = (bytes_left_r != '0) ? bytes_left_r - 9'd1 : bytes_left_r;
  assign count_sat   = (tick.byte_count == '0)       ? 9'd1 :
                       (tick.byte_count > MAX_BYTES) ? MAX_BYTES : tick.byte_count;
  // data byte is picked up on the first bit of a write data byte
  assign shift_ld    = (stage_r == STG_WDATA && bit_cnt_r == '0) ? tick.write_data : shift_r;
  assign rx_shift    = {shift_r[6:0], tick.sda_in};

  always_comb begin
    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    read_mode_nxt  = read_mode_r;
    reg_addr_nxt   = reg_addr_r;

    res              = '0;
    res.scl_release  = 1'b1;
    res.sda_release  = 1'b1;
    res.busy_res     = 1'b1;

    unique case (phase_r)
      PH_IDLE: begin
        res.busy_res = 1'b0;
        if (tick.start_cmd) begin
          bytes_left_nxt = count_sat;
          read_mode_nxt  = tick.operation;
          reg_addr_nxt   = tick.reg_address;
          res.busy_res   = 1'b1;
          phase_nxt      = PH_S_FALL;
        end
      end
      PH_S_FALL: begin
        res.sda_release = 1'b0;
        phase_nxt       = PH_S_LOW;
      end
      PH_S_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
        shift_nxt       = dev_addr;
        bit_cnt_nxt     = '0;
        stage_nxt       = STG_DEV;
        phase_nxt       = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        shift_nxt       = shift_ld;
        res.scl_release = 1'b0;
        res.sda_release = shift_ld[7];
        phase_nxt       = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        res.sda_release = shift_r[7];
        shift_nxt       = {shift_r[6:0], 1'b0};
        if (bit_cnt_inc >= BITS_PER_BYTE) begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_ACK_LOW;
        end else begin
          bit_cnt_nxt = bit_cnt_inc;
          phase_nxt   = PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: begin
        res.scl_release = 1'b0;
        phase_nxt       = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        // slave nack is flagged, the transfer carries on
        res.nack_seen = tick.sda_in;
        bit_cnt_nxt   = '0;
        case (stage_r)
          STG_DEV: begin
            shift_nxt = reg_addr_r;
            stage_nxt = STG_REG;
            phase_nxt = PH_BIT_LOW;
          end
          STG_REG: begin
            if (read_mode_r) begin
              phase_nxt = PH_RS_REL;
            end else begin
              res.byte_request = 1'b1;
              shift_nxt        = '0;
              stage_nxt        = STG_WDATA;
              phase_nxt        = PH_BIT_LOW;
            end
          end
          STG_WDATA: begin
            bytes_left_nxt = bytes_dec;
            if (bytes_dec == '0) begin
              phase_nxt = PH_P_LOW;
            end else begin
              res.byte_request = 1'b1;
              shift_nxt        = '0;
              phase_nxt        = PH_BIT_LOW;
            end
          end
          default: begin
            shift_nxt = '0;
            phase_nxt = PH_RX_LOW;
          end
        endcase
      end
      PH_RX_LOW: begin
        res.scl_release = 1'b0;
        phase_nxt       = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        shift_nxt = rx_shift;
        if (bit_cnt_inc >= BITS_PER_BYTE) begin
          bit_cnt_nxt    = '0;
          res.read_valid = 1'b1;
          res.read_data  = rx_shift;
          bytes_left_nxt = bytes_dec;
          phase_nxt      = PH_MACK_LOW;
        end else begin
          bit_cnt_nxt = bit_cnt_inc;
          phase_nxt   = PH_RX_LOW;
        end
      end
      PH_MACK_LOW: begin
        // ack while more bytes follow, nack on the last one
        res.sda_release = (bytes_left_r == '0);
        res.scl_release = 1'b0;
        phase_nxt       = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        res.sda_release = (bytes_left_r == '0);
        if (bytes_left_r != '0) begin
          shift_nxt   = '0;
          bit_cnt_nxt = '0;
          phase_nxt   = PH_RX_LOW;
        end else begin
          phase_nxt = PH_P_LOW;
        end
      end
      PH_RS_REL: begin
        res.scl_release = 1'b0;
        phase_nxt       = PH_RS_HIGH;
      end
      PH_RS_HIGH: begin
        phase_nxt = PH_RS_FALL;
      end
      PH_RS_FALL: begin
        res.sda_release = 1'b0;
        phase_nxt       = PH_RS_LOW;
      end
      PH_RS_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
        shift_nxt       = dev_addr + 8'd1;
        bit_cnt_nxt     = '0;
        stage_nxt       = STG_RADR;
        phase_nxt       = PH_BIT_LOW;
      end
      PH_P_LOW: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
        phase_nxt       = PH_P_HIGH;
      end
      PH_P_HIGH: begin
        res.sda_release = 1'b0;
        phase_nxt       = PH_P_REL;
      end
      PH_P_REL: begin
        res.busy_res = 1'b0;
        res.done_res = 1'b1;
        phase_nxt    = PH_IDLE;
      end
      default: begin
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      stage_r      <= STG_DEV;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      bytes_left_r <= '0;
      read_mode_r  <= 1'b0;
      reg_addr_r   <= '0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      stage_r      <= stage_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      read_mode_r  <= read_mode_nxt;
      reg_addr_r   <= reg_addr_nxt;
    end
  end

  a_bytes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= MAX_BYTES)
    else $error("byte counter above limit");

  a_bit_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < BITS_PER_BYTE)
    else $error("bit counter out of range");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done_res |-> !res.busy_res)
    else $error("done while busy");

  a_req_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.byte_request |=> phase_r == PH_BIT_LOW && stage_r == STG_WDATA)
    else $error("byte request not followed by data load");

endmodule

@@ tb/tb_i2c_register_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_master
// Self-checking testbench for the I2C register master.
// ----------------------------------------------------------------------------
// Bus phase ticks go in through the valid/stall input channel. A behavioral
// model of the phase sequencer predicts the SCL/SDA levels and the flags of
// every tick, and each result transaction is checked field by field against
// the oldest prediction. Directed transfers cover the default device address,
// the address register extremes and wrap of the read address, byte count
// clamping, slave NACKs, all-ones and all-zeros data and commands issued
// while busy. Random transfers follow, with random gaps on the input side
// and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_i2c_register_master;
  import i2crm_pkg::*;

  localparam int RANDOM_TICKS = 200;
  localparam int MAX_REPORTS  = 50;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en;
  logic [ADDR_W-1:0] cfg_wr_data;

  always #1 clk = ~clk;

  i2c_register_master dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // sequencer model state
  phase_t               bus_phase   = PH_IDLE;
  stage_t               byte_stage  = STG_DEV;
  logic [BIT_CNT_W-1:0] bit_count   = '0;
  logic [7:0]           shift_byte  = '0;
  logic [COUNT_W-1:0]   bytes_left  = '0;
  logic                 read_xfer   = 1'b0;
  logic [ADDR_W-1:0]    held_reg    = '0;
  logic [ADDR_W-1:0]    dev_address = DEV_ADDR_RST;

  out_item_t pending_bus_ticks[$];
  int        mismatch_count = 0;
  int        ticks_sent     = 0;
  int        stall_left     = 0;

  // stimulus knobs
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int nack_pct      = 5;
  int sda_high_pct  = 50;
  int wdata_fill    = -1;
  bit busy_cmd_on   = 1'b0;

  function automatic void load_byte(stage_t stg, logic [7:0] value);
    shift_byte = value;
    bit_count  = '0;
    byte_stage = stg;
    bus_phase  = PH_BIT_LOW;
  endfunction

  function automatic out_item_t predict_bus_tick(in_item_t t);
    out_item_t          r;
    logic [COUNT_W-1:0] n;
    r             = '0;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    r.busy_res    = 1'b1;
    case (bus_phase)
      PH_IDLE: begin
        r.busy_res = 1'b0;
        if (t.start_cmd) begin
          n = t.byte_count;
          if (n == 0) n = 9'd1;
          if (n > MAX_BYTES) n = MAX_BYTES;
          bytes_left = n;
          read_xfer  = t.operation;
          held_reg   = t.reg_address;
          r.busy_res = 1'b1;
          bus_phase  = PH_S_FALL;
        end
      end
      PH_S_FALL: begin
        r.sda_release = 1'b0;
        bus_phase     = PH_S_LOW;
      end
      PH_S_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
        load_byte(STG_DEV, dev_address);
      end
      PH_BIT_LOW: begin
        // data byte is picked up on the first bit of each write data byte
        if (byte_stage == STG_WDATA && bit_count == 0) shift_byte = t.write_data;
        r.scl_release = 1'b0;
        r.sda_release = shift_byte[7];
        bus_phase     = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.sda_release = shift_byte[7];
        shift_byte    = {shift_byte[6:0], 1'b0};
        bit_count     = bit_count + 4'd1;
        if (bit_count >= BITS_PER_BYTE) begin
          bit_count = '0;
          bus_phase = PH_ACK_LOW;
        end else begin
          bus_phase = PH_BIT_LOW;
        end
      end
      PH_ACK_LOW: begin
        r.scl_release = 1'b0;
        bus_phase     = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        r.nack_seen = t.sda_in;
        case (byte_stage)
          STG_DEV: load_byte(STG_REG, held_reg);
          STG_REG: begin
            if (read_xfer) begin
              bus_phase = PH_RS_REL;
            end else begin
              r.byte_request = 1'b1;
              load_byte(STG_WDATA, 8'h00);
            end
          end
          STG_WDATA: begin
            if (bytes_left != 0) bytes_left = bytes_left - 9'd1;
            if (bytes_left == 0) begin
              bus_phase = PH_P_LOW;
            end else begin
              r.byte_request = 1'b1;
              load_byte(STG_WDATA, 8'h00);
            end
          end
          STG_RADR: begin
            shift_byte = '0;
            bit_count  = '0;
            bus_phase  = PH_RX_LOW;
          end
        endcase
      end
      PH_RX_LOW: begin
        r.scl_release = 1'b0;
        bus_phase     = PH_RX_HIGH;
      end
      PH_RX_HIGH: begin
        shift_byte = {shift_byte[6:0], t.sda_in};
        bit_count  = bit_count + 4'd1;
        if (bit_count >= BITS_PER_BYTE) begin
          bit_count    = '0;
          r.read_valid = 1'b1;
          r.read_data  = shift_byte;
          if (bytes_left != 0) bytes_left = bytes_left - 9'd1;
          bus_phase = PH_MACK_LOW;
        end else begin
          bus_phase = PH_RX_LOW;
        end
      end
      PH_MACK_LOW, PH_MACK_HIGH: begin
        // master acks every byte but the last
        r.sda_release = (bytes_left == 0);
        if (bus_phase == PH_MACK_LOW) begin
          r.scl_release = 1'b0;
          bus_phase     = PH_MACK_HIGH;
        end else if (bytes_left != 0) begin
          shift_byte = '0;
          bit_count  = '0;
          bus_phase  = PH_RX_LOW;
        end else begin
          bus_phase = PH_P_LOW;
        end
      end
      PH_RS_REL: begin
        r.scl_release = 1'b0;
        bus_phase     = PH_RS_HIGH;
      end
      PH_RS_HIGH: bus_phase = PH_RS_FALL;
      PH_RS_FALL: begin
        r.sda_release = 1'b0;
        bus_phase     = PH_RS_LOW;
      end
      PH_RS_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
        load_byte(STG_RADR, 8'(dev_address + 8'd1));
      end
      PH_P_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
        bus_phase     = PH_P_HIGH;
      end
      PH_P_HIGH: begin
        r.sda_release = 1'b0;
        bus_phase     = PH_P_REL;
      end
      PH_P_REL: begin
        r.busy_res = 1'b0;
        r.done_res = 1'b1;
        bus_phase  = PH_IDLE;
      end
      default: begin
        r.busy_res = 1'b0;
        bus_phase  = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    // keep the log readable when a broken design fails every tick
    if (mismatch_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want)
      report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
  endtask

  // result check first, then prediction of the tick taken at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_bus_ticks.size() == 0) begin
          report_mismatch("result transaction with no tick pending");
        end else begin
          want = pending_bus_ticks.pop_front();
          check_field("scl_release", 8'(want.scl_release), 8'(out_data.scl_release));
          check_field("sda_release", 8'(want.sda_release), 8'(out_data.sda_release));
          check_field("byte_request", 8'(want.byte_request), 8'(out_data.byte_request));
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
          check_field("nack_seen", 8'(want.nack_seen), 8'(out_data.nack_seen));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        pending_bus_ticks.push_back(predict_bus_tick(in_data));
      if (cfg_wr_en === 1'b1) dev_address = cfg_wr_data;
    end
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(in_item_t t);
    int gap;
    gap = pick_gap(in_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    ticks_sent++;
  endtask

  function automatic in_item_t make_tick();
    in_item_t t;
    t.start_cmd   = busy_cmd_on ? 1'b1 : 1'($urandom_range(1));
    t.operation   = 1'($urandom_range(1));
    t.reg_address = 8'($urandom);
    t.byte_count  = 9'($urandom);
    t.write_data  = (wdata_fill < 0) ? 8'($urandom) : 8'(wdata_fill);
    // slave answers on the ack clock, otherwise sda_in is read data or noise
    if (bus_phase == PH_ACK_HIGH) t.sda_in = ($urandom_range(99) < nack_pct);
    else t.sda_in = ($urandom_range(99) < sda_high_pct);
    return t;
  endfunction

  task automatic drain(int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_bus_ticks.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_dev_address(logic [ADDR_W-1:0] value);
    drain(4);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_idle_ticks(int count);
    in_item_t t;
    repeat (count) begin
      t           = make_tick();
      t.start_cmd = 1'b0;
      send_tick(t);
    end
  endtask

  // one bus transaction from start command to stop; drain_at pauses the sender
  task automatic run_transfer(logic op, logic [ADDR_W-1:0] reg_addr,
                              logic [COUNT_W-1:0] count, int drain_at);
    in_item_t t;
    int       n;
    t             = make_tick();
    t.start_cmd   = 1'b1;
    t.operation   = op;
    t.reg_address = reg_addr;
    t.byte_count  = count;
    send_tick(t);
    n = 1;
    while (bus_phase != PH_IDLE) begin
      if (n == drain_at) drain(0);
      send_tick(make_tick());
      n++;
    end
  endtask

  task automatic test_default_address();
    run_transfer(1'b0, 8'h00, 9'd1, 0);
    send_idle_ticks(2);
    run_transfer(1'b1, 8'hFF, 9'd1, 0);
  endtask

  task automatic test_byte_count_edges();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    run_transfer(1'b0, 8'hA5, 9'd0, 0);
    run_transfer(1'b1, 8'h5A, 9'd0, 0);
    run_transfer(1'b0, 8'h3C, 9'd3, 0);
    run_transfer(1'b1, 8'hC3, 9'd3, 0);
  endtask

  task automatic test_address_register();
    write_dev_address(8'h00);
    run_transfer(1'b1, 8'h11, 9'd2, 0);
    // read address wraps to zero
    write_dev_address(8'hFF);
    run_transfer(1'b1, 8'h22, 9'd2, 0);
    run_transfer(1'b0, 8'h33, 9'd1, 0);
    write_dev_address(8'hFE);
    run_transfer(1'b1, 8'h44, 9'd1, 0);
  endtask

  task automatic test_line_extremes();
    nack_pct     = 100;
    sda_high_pct = 100;
    wdata_fill   = 8'hFF;
    run_transfer(1'b0, 8'hFF, 9'd2, 0);
    run_transfer(1'b1, 8'hFF, 9'd2, 0);
    nack_pct     = 0;
    sda_high_pct = 0;
    wdata_fill   = 8'h00;
    run_transfer(1'b0, 8'h00, 9'd2, 0);
    run_transfer(1'b1, 8'h00, 9'd2, 0);
    nack_pct     = 5;
    sda_high_pct = 50;
    wdata_fill   = -1;
  endtask

  task automatic test_busy_commands();
    busy_cmd_on = 1'b1;
    run_transfer(1'b0, 8'h69, 9'd2, 0);
    run_transfer(1'b1, 8'h96, 9'd2, 0);
    busy_cmd_on = 1'b0;
  endtask

  task automatic test_drain_midway();
    in_gap_pct    = 30;
    out_stall_pct = 60;
    run_transfer(1'b0, 8'($urandom), 9'd4, 20);
    run_transfer(1'b1, 8'($urandom), 9'd4, 45);
  endtask

  task automatic test_random_traffic();
    int                 first_tick;
    int                 pick;
    int                 drain_at;
    logic [COUNT_W-1:0] count;
    first_tick = ticks_sent;
    while (ticks_sent - first_tick < RANDOM_TICKS) begin
      if ($urandom_range(7) == 0) begin
        in_gap_pct    = ($urandom_range(2) == 0) ? 0 : $urandom_range(50);
        out_stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50);
      end
      if ($urandom_range(7) == 0) begin
        pick = $urandom_range(3);
        if (pick == 0) write_dev_address(8'h00);
        else if (pick == 1) write_dev_address(8'hFF);
        else write_dev_address(8'($urandom));
      end
      nack_pct     = ($urandom_range(3) == 0) ? $urandom_range(100) : 5;
      sda_high_pct = $urandom_range(100);
      busy_cmd_on  = ($urandom_range(3) == 0);
      // mostly short transfers, now and then a longer one
      pick = $urandom_range(99);
      if (pick < 85) count = 9'($urandom_range(6));
      else count = 9'($urandom_range(16, 7));
      drain_at = ($urandom_range(7) == 0) ? $urandom_range(40, 2) : 0;
      send_idle_ticks($urandom_range(3));
      run_transfer(1'($urandom_range(1)), 8'($urandom), count, drain_at);
    end
    busy_cmd_on = 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    drain(2);
    test_default_address();
    test_byte_count_edges();
    test_address_register();
    test_line_extremes();
    test_busy_commands();
    test_drain_midway();
    test_random_traffic();
    drain(8);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
